// ===== sv/reflow_profile_sequencer_macros.svh =====
// Assertion macros for the reflow profile sequencer.
`ifndef REFLOW_PROFILE_SEQUENCER_MACROS_SVH
`define REFLOW_PROFILE_SEQUENCER_MACROS_SVH

// Check c whenever a holds, in the same cycle.
`define RPS_ASSERT_NOW(label, a, c) \
  label: assert property (@(posedge clk) disable iff (rst) (a) |-> (c)) \
    else $error("reflow sequencer check failed");

// Check c in the cycle after a holds.
`define RPS_ASSERT_NEXT(label, a, c) \
  label: assert property (@(posedge clk) disable iff (rst) (a) |=> (c)) \
    else $error("reflow sequencer check failed");

`endif

// ===== sv/rps_pkg.sv =====
// Shared types, constants and register defaults for the reflow profile sequencer.
package rps_pkg;

  localparam int MAX_PHASES_DEF = 6;
  localparam int PHASE_SLOTS    = 6;

  localparam int REG_IDX_W = 3;
  localparam int BYTE_W    = 3;
  localparam int ADDR_W    = REG_IDX_W + BYTE_W;
  localparam int DATA_W    = 64;

  localparam int WORD_W   = 55;
  localparam int TEMP_W   = 9;
  localparam int MS_W     = 18;
  localparam int TIME_W   = 32;
  localparam int INTEMP_W = 14;
  localparam int SP_W     = 13;
  localparam int PHASE_W  = 3;
  localparam int PC_W     = 3;
  localparam int Q4_SHIFT = 4;
  localparam int DIV_N_W  = TEMP_W + MS_W + 1 + Q4_SHIFT;

  localparam logic [REG_IDX_W-1:0] REG_PHASE_COUNT      = 3'd0;
  localparam logic [REG_IDX_W-1:0] REG_PHASE_WORD_FIRST = 3'd1;

  localparam logic [PC_W-1:0] PHASE_COUNT_RESET = 3'd5;

  localparam logic [WORD_W-1:0] WORD_RESET [PHASE_SLOTS] = '{
    55'd12369552998476800, 55'd8246368665692310, 55'd8246355558520500,
    55'd1374397399160555, 55'd6184776499200220, 55'd0
  };

  typedef struct packed {
    logic              rate;
    logic [MS_W-1:0]   max_ms;
    logic [MS_W-1:0]   min_ms;
    logic [TEMP_W-1:0] end_c;
    logic [TEMP_W-1:0] start_c;
  } phase_t;

  typedef struct packed {
    logic               start;
    logic [DIV_N_W-1:0] dividend;
    logic [MS_W-1:0]    divisor;
  } div_req_t;

  typedef struct packed {
    logic               busy;
    logic [DIV_N_W-1:0] quotient;
  } div_rsp_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_UPD,
    S_RDLAST,
    S_RDSP,
    S_SEL,
    S_WALK,
    S_MULA,
    S_MULB,
    S_DIVST,
    S_DIV,
    S_OUT
  } state_t;

  function automatic phase_t to_phase(input logic [WORD_W-1:0] w);
    return phase_t'(w);
  endfunction

endpackage

// ===== sv/rps_divider.sv =====
// Shift-subtract divider, one quotient bit per cycle.
module rps_divider #(
  parameter int N_W = rps_pkg::DIV_N_W,
  parameter int D_W = rps_pkg::MS_W
) (
  input  logic                clk,
  input  logic                rst,
  input  rps_pkg::div_req_t   req,
  output rps_pkg::div_rsp_t   rsp
);

  localparam int CW = $clog2(N_W + 1);

  logic [N_W-1:0] quo;
  logic [D_W-1:0] rem;
  logic [D_W-1:0] divisor;
  logic [CW-1:0]  count;
  logic           busy;

  logic [D_W:0]   rem_sh;
  logic [D_W+1:0] diff;
  logic           ge;

  always_comb begin
    rem_sh = {rem, quo[N_W-1]};
    diff   = {1'b0, rem_sh} - {2'b00, divisor};
    ge     = !diff[D_W+1];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy  <= 1'b0;
      count <= '0;
    end else if (req.start) begin
      busy  <= 1'b1;
      count <= CW'(N_W);
    end else if (busy) begin
      count <= count - 1'b1;
      if (count == CW'(1)) begin
        busy <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (req.start) begin
      quo     <= req.dividend;
      rem     <= '0;
      divisor <= req.divisor;
    end else if (busy) begin
      rem <= ge ? diff[D_W-1:0] : rem_sh[D_W-1:0];
      quo <= {quo[N_W-2:0], ge};
    end
  end

  assign rsp.busy     = busy;
  assign rsp.quotient = quo;

endmodule

// ===== sv/rps_cfg_regs.sv =====
// APB register file: phase count and the phase word store with two read ports.
module rps_cfg_regs #(
  parameter int MAX_PHASES = rps_pkg::MAX_PHASES_DEF,
  parameter int IDX_W      = 3,
  parameter int CNT_W      = 3
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [rps_pkg::ADDR_W-1:0]  paddr,
  input  logic [rps_pkg::DATA_W-1:0]  pwdata,
  output logic [rps_pkg::DATA_W-1:0]  prdata,
  output logic                        pready,
  output logic [rps_pkg::PC_W-1:0]    phase_count,
  input  logic [CNT_W-1:0]            rd_addr,
  output rps_pkg::phase_t             rd_word
);

  logic [rps_pkg::WORD_W-1:0]    mem [MAX_PHASES];
  logic [MAX_PHASES-1:0]         written;

  logic [rps_pkg::REG_IDX_W-1:0] reg_idx;
  logic [rps_pkg::REG_IDX_W-1:0] slot;
  logic [IDX_W-1:0]              slot_i;
  logic [IDX_W-1:0]              ra;
  logic                          wr;
  logic                          word_sel;

  always_comb begin
    reg_idx  = paddr[rps_pkg::ADDR_W-1:rps_pkg::BYTE_W];
    slot     = reg_idx - rps_pkg::REG_PHASE_WORD_FIRST;
    slot_i   = slot[IDX_W-1:0];
    ra       = rd_addr[IDX_W-1:0];
    wr       = psel && penable && pwrite;
    word_sel = (reg_idx inside {[rps_pkg::REG_PHASE_WORD_FIRST :
                  rps_pkg::REG_PHASE_WORD_FIRST + rps_pkg::PHASE_SLOTS - 1]}) &&
               (slot < rps_pkg::REG_IDX_W'(MAX_PHASES));
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase_count <= rps_pkg::PHASE_COUNT_RESET;
      written     <= '0;
    end else if (wr) begin
      if (reg_idx == rps_pkg::REG_PHASE_COUNT) begin
        phase_count <= pwdata[rps_pkg::PC_W-1:0];
      end else if (word_sel) begin
        written[slot_i] <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (wr && word_sel) begin
      mem[slot_i] <= pwdata[rps_pkg::WORD_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rd_addr < CNT_W'(MAX_PHASES)) begin
      rd_word <= rps_pkg::to_phase(written[ra] ? mem[ra] : rps_pkg::WORD_RESET[ra]);
    end else begin
      rd_word <= '0;
    end
  end

  always_ff @(posedge clk) begin
    if (reg_idx == rps_pkg::REG_PHASE_COUNT) begin
      prdata <= rps_pkg::DATA_W'(phase_count);
    end else if (word_sel) begin
      prdata <= rps_pkg::DATA_W'(written[slot_i] ? mem[slot_i]
                                                 : rps_pkg::WORD_RESET[slot_i]);
    end else begin
      prdata <= '0;
    end
  end

  assign pready = 1'b1;

endmodule

// ===== sv/reflow_profile_sequencer.sv =====
// Reflow profile sequencer top level: sequencer, datapath and output register.
// Each item passes through update and lookup states, a walk over the phases in use (up to
// six by default), two steps on the shared multiplier, a divider start state, the divider
// and the output load; the walk, multiply and divide steps are skipped when not needed.
// One item is in work at a time, so a new item is taken only once the last result is loaded, which waits for out_ready.
// Reset is synchronous; registers return to their listed defaults at once, no clearing pass.
`include "reflow_profile_sequencer_macros.svh"
module reflow_profile_sequencer #(
  parameter int MAX_PHASES = rps_pkg::MAX_PHASES_DEF
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                in_valid,
  output logic                                in_ready,
  input  logic                                action,
  input  logic [rps_pkg::TIME_W-1:0]          now_ms,
  input  logic signed [rps_pkg::INTEMP_W-1:0] actual_temp_q4,
  output logic                                out_valid,
  input  logic                                out_ready,
  output logic [rps_pkg::PHASE_W-1:0]         phase_index,
  output logic                                complete,
  output logic                                advanced,
  output logic [rps_pkg::SP_W-1:0]            setpoint_q4,
  input  logic                                psel,
  input  logic                                penable,
  input  logic                                pwrite,
  input  logic [rps_pkg::ADDR_W-1:0]          paddr,
  input  logic [rps_pkg::DATA_W-1:0]          pwdata,
  output logic [rps_pkg::DATA_W-1:0]          prdata,
  output logic                                pready
);

  localparam int IDX_W  = (MAX_PHASES > 1) ? $clog2(MAX_PHASES) : 1;
  localparam int CNT_W  = $clog2(MAX_PHASES + 1);
  localparam int ACC_W  = rps_pkg::MS_W + CNT_W;
  localparam int PROD_W = rps_pkg::TEMP_W + rps_pkg::MS_W;
  localparam int NUM_W  = PROD_W + 1;
  localparam int TW     = rps_pkg::TIME_W;
  localparam int MW     = rps_pkg::MS_W;
  localparam int SW     = rps_pkg::SP_W;
  localparam int Q4     = rps_pkg::Q4_SHIFT;

  rps_pkg::state_t   state, state_next;
  rps_pkg::phase_t   rd_word;
  rps_pkg::div_req_t div_req;
  rps_pkg::div_rsp_t div_rsp;

  logic [rps_pkg::PC_W-1:0] phase_count;
  logic [CNT_W-1:0]         n;
  logic [CNT_W-1:0]         rd_addr;

  logic                                act;
  logic [TW-1:0]                       now_r;
  logic signed [rps_pkg::INTEMP_W-1:0] temp_r;

  logic [IDX_W-1:0] cur;
  logic             done;
  logic [TW-1:0]    reflow_start;
  logic [TW-1:0]    phase_start;
  logic             stamped;
  logic             adv;

  logic [SW-1:0]    last_end;
  logic [SW-1:0]    result;
  logic [TW-1:0]    elapsed_r;
  logic [ACC_W-1:0] pstart;
  logic [CNT_W-1:0] widx;
  logic [rps_pkg::TEMP_W-1:0] seg_start, seg_end;
  logic [MW-1:0]    seg_min, seg_d;
  logic [NUM_W-1:0] acc;

  logic [CNT_W-1:0] cur_ext;
  logic             cur_in_range;
  logic             cur_last;
  logic [TW-1:0]    stamp_ms;
  logic [TW-1:0]    elapsed_upd;
  logic             phase_end;
  logic [ACC_W-1:0] pend;
  logic             in_seg;
  logic [TW-1:0]    d_raw;
  logic [MW-1:0]    d_clamped;
  logic             walk_done;
  logic             show_last;
  logic [SW-1:0]    end_q4;
  logic [rps_pkg::TEMP_W-1:0] mul_a;
  logic [MW-1:0]    mul_b;
  logic [PROD_W-1:0] prod;
  logic             load_out;

  rps_cfg_regs #(
    .MAX_PHASES (MAX_PHASES),
    .IDX_W      (IDX_W),
    .CNT_W      (CNT_W)
  ) u_cfg (
    .clk         (clk),
    .rst         (rst),
    .psel        (psel),
    .penable     (penable),
    .pwrite      (pwrite),
    .paddr       (paddr),
    .pwdata      (pwdata),
    .prdata      (prdata),
    .pready      (pready),
    .phase_count (phase_count),
    .rd_addr     (rd_addr),
    .rd_word     (rd_word)
  );

  rps_divider #(
    .N_W (rps_pkg::DIV_N_W),
    .D_W (MW)
  ) u_div (
    .clk (clk),
    .rst (rst),
    .req (div_req),
    .rsp (div_rsp)
  );

  always_comb begin
    n = (phase_count > rps_pkg::PC_W'(MAX_PHASES)) ? CNT_W'(MAX_PHASES)
                                                   : CNT_W'(phase_count);
    cur_ext      = CNT_W'(cur);
    cur_in_range = cur_ext < n;
    cur_last     = (cur_ext + 1'b1) >= n;
    show_last    = done || (n == '0) || !cur_in_range;
    end_q4       = {rd_word.end_c, {Q4{1'b0}}};

    stamp_ms    = stamped ? phase_start : now_r;
    elapsed_upd = now_r - stamp_ms;
    phase_end   = ((temp_r >= $signed({1'b0, end_q4})) &&
                   (elapsed_upd >= TW'(rd_word.min_ms))) ||
                  (elapsed_upd >= TW'(rd_word.max_ms));

    pend      = pstart + ACC_W'(rd_word.min_ms);
    in_seg    = elapsed_r <= TW'(pend);
    d_raw     = elapsed_r - TW'(pstart);
    if (elapsed_r < TW'(pstart)) begin
      d_clamped = '0;
    end else if (d_raw > TW'(rd_word.min_ms)) begin
      d_clamped = rd_word.min_ms;
    end else begin
      d_clamped = d_raw[MW-1:0];
    end
    walk_done = widx >= n;

    mul_a = (state == rps_pkg::S_MULA) ? seg_start : seg_end;
    mul_b = (state == rps_pkg::S_MULA) ? (seg_min - seg_d) : seg_d;
    prod  = mul_a * mul_b;

    load_out = (state == rps_pkg::S_OUT) && (!out_valid || out_ready);
  end

  // next state
  always_comb begin
    state_next = state;
    case (state)
      rps_pkg::S_IDLE:   if (in_valid) state_next = rps_pkg::S_UPD;
      rps_pkg::S_UPD:    state_next = rps_pkg::S_RDLAST;
      rps_pkg::S_RDLAST: state_next = rps_pkg::S_RDSP;
      rps_pkg::S_RDSP:   state_next = rps_pkg::S_SEL;
      rps_pkg::S_SEL: begin
        if (show_last || rd_word.rate) state_next = rps_pkg::S_OUT;
        else state_next = rps_pkg::S_WALK;
      end
      rps_pkg::S_WALK: begin
        if (walk_done) state_next = rps_pkg::S_OUT;
        else if (in_seg) begin
          state_next = (rd_word.min_ms == '0) ? rps_pkg::S_OUT : rps_pkg::S_MULA;
        end
      end
      rps_pkg::S_MULA:  state_next = rps_pkg::S_MULB;
      rps_pkg::S_MULB:  state_next = rps_pkg::S_DIVST;
      rps_pkg::S_DIVST: state_next = rps_pkg::S_DIV;
      rps_pkg::S_DIV:   if (!div_rsp.busy) state_next = rps_pkg::S_OUT;
      rps_pkg::S_OUT:   if (load_out) state_next = rps_pkg::S_IDLE;
      default:          state_next = rps_pkg::S_IDLE;
    endcase
  end

  // sequencer outputs
  always_comb begin
    in_ready         = 1'b0;
    rd_addr          = cur_ext;
    div_req.start    = 1'b0;
    div_req.dividend = {acc, {Q4{1'b0}}};
    div_req.divisor  = seg_min;
    case (state)
      rps_pkg::S_IDLE:   in_ready = 1'b1;
      rps_pkg::S_RDLAST: rd_addr = n - 1'b1;
      rps_pkg::S_SEL:    rd_addr = '0;
      rps_pkg::S_WALK:   rd_addr = widx + 1'b1;
      rps_pkg::S_DIVST:  div_req.start = 1'b1;
      default:           rd_addr = cur_ext;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= rps_pkg::S_IDLE;
      cur          <= '0;
      done         <= 1'b0;
      reflow_start <= '0;
      phase_start  <= '0;
      stamped      <= 1'b0;
      out_valid    <= 1'b0;
    end else begin
      state <= state_next;
      if (state == rps_pkg::S_UPD) begin
        if (act) begin
          reflow_start <= now_r;
          cur          <= '0;
          done         <= 1'b0;
          phase_start  <= now_r;
          stamped      <= (n != '0);
        end else if (!done) begin
          if (!cur_in_range) begin
            done <= 1'b1;
          end else begin
            if (!stamped) begin
              phase_start <= now_r;
            end
            stamped <= !phase_end;
            if (phase_end) begin
              if (cur_last) done <= 1'b1;
              else cur <= IDX_W'(cur_ext + 1'b1);
            end
          end
        end
      end
      if (load_out) out_valid <= 1'b1;
      else if (out_ready) out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    case (state)
      rps_pkg::S_IDLE: begin
        if (in_valid) begin
          act    <= action;
          now_r  <= now_ms;
          temp_r <= actual_temp_q4;
        end
      end
      rps_pkg::S_UPD: begin
        adv <= !act && !done && cur_in_range && phase_end;
      end
      rps_pkg::S_RDSP: begin
        last_end <= (n != '0) ? end_q4 : '0;
      end
      rps_pkg::S_SEL: begin
        elapsed_r <= now_r - reflow_start;
        pstart    <= '0;
        widx      <= '0;
        if (show_last) result <= last_end;
        else if (rd_word.rate) result <= end_q4;
      end
      rps_pkg::S_WALK: begin
        if (walk_done) begin
          result <= last_end;
        end else if (in_seg) begin
          result    <= end_q4;
          seg_start <= rd_word.start_c;
          seg_end   <= rd_word.end_c;
          seg_min   <= rd_word.min_ms;
          seg_d     <= d_clamped;
        end else begin
          pstart <= pend;
          widx   <= widx + 1'b1;
        end
      end
      rps_pkg::S_MULA: acc <= NUM_W'(prod);
      rps_pkg::S_MULB: acc <= acc + NUM_W'(prod);
      rps_pkg::S_DIV: begin
        if (!div_rsp.busy) result <= div_rsp.quotient[SW-1:0];
      end
      default: begin
      end
    endcase
    if (load_out) begin
      phase_index <= done ? '0 : rps_pkg::PHASE_W'(cur);
      complete    <= done;
      advanced    <= adv;
      setpoint_q4 <= result;
    end
  end

  `RPS_ASSERT_NOW(a_ready_div_idle, in_ready, !div_rsp.busy)
  `RPS_ASSERT_NOW(a_div_in_div_state, div_rsp.busy, state == rps_pkg::S_DIV)
  `RPS_ASSERT_NEXT(a_busy_after_take, in_valid && in_ready, !in_ready)
  `RPS_ASSERT_NOW(a_cur_in_store, 1'b1, CNT_W'(cur) < CNT_W'(MAX_PHASES))

endmodule

// ===== tb/sv/tb_reflow_profile_sequencer.sv =====
// Self-checking testbench for the reflow profile sequencer: random and directed items, APB setup.
module tb_reflow_profile_sequencer;
  import rps_pkg::*;

  localparam logic ACT_TICK  = 1'b0;
  localparam logic ACT_START = 1'b1;
  localparam int SETTLE_CYCLES = 60;
  localparam int LONG_HOLD_CYCLES = 400;
  localparam int ROUND_ITEMS = 100;
  localparam int ROUND_COUNTS [8] = '{6, 3, 7, 1, 5, 0, 4, 2};

  typedef struct {
    logic                       act;
    logic [TIME_W-1:0]          t;
    logic signed [INTEMP_W-1:0] temp;
  } oven_cmd_t;

  typedef struct {
    logic [PHASE_W-1:0] phase;
    logic               done;
    logic               adv;
    logic [SP_W-1:0]    sp;
  } oven_status_t;

  logic clk = 1'b0;
  logic rst;
  logic in_valid;
  logic in_ready;
  logic action;
  logic [TIME_W-1:0] now_ms;
  logic signed [INTEMP_W-1:0] actual_temp_q4;
  logic out_valid;
  logic out_ready;
  logic [PHASE_W-1:0] phase_index;
  logic complete;
  logic advanced;
  logic [SP_W-1:0] setpoint_q4;
  logic psel;
  logic penable;
  logic pwrite;
  logic [ADDR_W-1:0] paddr;
  logic [DATA_W-1:0] pwdata;
  logic [DATA_W-1:0] prdata;
  logic pready;

  reflow_profile_sequencer dut (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_ready(in_ready),
    .action(action), .now_ms(now_ms), .actual_temp_q4(actual_temp_q4),
    .out_valid(out_valid), .out_ready(out_ready),
    .phase_index(phase_index), .complete(complete), .advanced(advanced),
    .setpoint_q4(setpoint_q4),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready)
  );

  oven_cmd_t oven_cmds[$];
  oven_status_t status_due[$];
  oven_cmd_t nxt;
  oven_status_t want;

  int send_idle;
  int recv_idle;
  logic long_hold_req;
  logic long_hold_seen;
  int hold_left;
  int fail_count = 0;

  logic [PC_W-1:0] m_count;
  phase_t m_prof [PHASE_SLOTS];
  logic [PHASE_W-1:0] m_phase;
  logic m_done;
  logic [TIME_W-1:0] m_reflow_t;
  logic [TIME_W-1:0] m_phase_t;
  logic m_stamped;

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  function automatic int unsigned phases_used();
    return (m_count > PHASE_SLOTS) ? PHASE_SLOTS : m_count;
  endfunction

  function automatic logic [SP_W-1:0] last_end_q4(input int unsigned n);
    return (n > 0) ? {m_prof[n-1].end_c, 4'd0} : '0;
  endfunction

  function automatic logic [SP_W-1:0] profile_setpoint(input logic [TIME_W-1:0] now);
    int unsigned n;
    int unsigned i;
    logic [TIME_W-1:0] el;
    logic [TIME_W-1:0] pst;
    logic [TIME_W-1:0] pen;
    logic [TIME_W-1:0] mn;
    logic [TIME_W-1:0] d;
    logic [63:0] num;
    n = phases_used();
    if (m_done || n == 0 || m_phase >= n) return last_end_q4(n);
    if (m_prof[m_phase].rate) return {m_prof[m_phase].end_c, 4'd0};
    el = now - m_reflow_t;
    pst = '0;
    for (i = 0; i < n; i++) begin
      mn = TIME_W'(m_prof[i].min_ms);
      pen = pst + mn;
      if (el <= pen) begin
        if (mn == 0) return {m_prof[i].end_c, 4'd0};
        d = (el >= pst) ? el - pst : '0;
        if (d > mn) d = mn;
        num = 64'(m_prof[i].start_c) * 64'(mn - d) + 64'(m_prof[i].end_c) * 64'(d);
        num = (num * 64'd16) / 64'(mn);
        return num[SP_W-1:0];
      end
      pst = pen;
    end
    return last_end_q4(n);
  endfunction

  function automatic void apply_cmd(input logic act, input logic [TIME_W-1:0] now,
                                    input logic signed [INTEMP_W-1:0] temp);
    int unsigned n;
    logic [TIME_W-1:0] el;
    logic adv;
    oven_status_t s;
    n = phases_used();
    adv = 1'b0;
    if (act == ACT_START) begin
      m_reflow_t = now;
      m_phase = '0;
      m_done = 1'b0;
      m_phase_t = now;
      m_stamped = (n > 0);
    end else if (!m_done) begin
      if (m_phase >= n) begin
        m_done = 1'b1;
      end else begin
        if (!m_stamped) begin
          m_phase_t = now;
          m_stamped = 1'b1;
        end
        el = now - m_phase_t;
        if ((int'(temp) >= int'({m_prof[m_phase].end_c, 4'd0}) && el >= m_prof[m_phase].min_ms)
            || el >= m_prof[m_phase].max_ms) begin
          adv = 1'b1;
          m_stamped = 1'b0;
          if (m_phase + 1 < n) m_phase = m_phase + 1'b1;
          else m_done = 1'b1;
        end
      end
    end
    s.phase = m_done ? '0 : m_phase;
    s.done = m_done;
    s.adv = adv;
    s.sp = profile_setpoint(now);
    status_due.push_back(s);
  endfunction

  function automatic void check_field(input string name, input logic [31:0] exp_v,
                                      input logic [31:0] got_v);
    if (got_v !== exp_v) begin
      $error("%s mismatch: expected %0d, got %0d", name, exp_v, got_v);
      fail_count++;
    end
  endfunction

  always @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (!in_valid || in_ready) begin
      if (oven_cmds.size() != 0 && $urandom_range(99) >= send_idle) begin
        nxt = oven_cmds.pop_front();
        in_valid <= 1'b1;
        action <= nxt.act;
        now_ms <= nxt.t;
        actual_temp_q4 <= nxt.temp;
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  always @(posedge clk) begin
    if (rst) begin
      out_ready <= 1'b0;
      hold_left <= 0;
      long_hold_seen <= 1'b0;
    end else if (long_hold_req && !long_hold_seen) begin
      long_hold_seen <= 1'b1;
      hold_left <= LONG_HOLD_CYCLES;
      out_ready <= 1'b0;
    end else if (hold_left != 0) begin
      hold_left <= hold_left - 1;
      out_ready <= 1'b0;
    end else begin
      out_ready <= ($urandom_range(99) >= recv_idle);
    end
  end

  always @(posedge clk) begin
    if (!rst) begin
      if (in_valid && in_ready) apply_cmd(action, now_ms, actual_temp_q4);
      if (out_valid && out_ready) begin
        if (status_due.size() == 0) begin
          $error("result with no item outstanding");
          fail_count++;
        end else begin
          want = status_due.pop_front();
          check_field("phase_index", 32'(want.phase), 32'(phase_index));
          check_field("complete", 32'(want.done), 32'(complete));
          check_field("advanced", 32'(want.adv), 32'(advanced));
          check_field("setpoint_q4", 32'(want.sp), 32'(setpoint_q4));
        end
      end
    end
  end

  task automatic push_cmd(input logic act, input logic [TIME_W-1:0] t, input int temp);
    oven_cmd_t c;
    c.act = act;
    c.t = t;
    c.temp = INTEMP_W'(temp);
    oven_cmds.push_back(c);
  endtask

  task automatic write_reg(input logic [REG_IDX_W-1:0] idx, input logic [DATA_W-1:0] val);
    @(posedge clk);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= {idx, 3'b000};
    pwdata <= val;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    if (idx == REG_PHASE_COUNT) m_count = val[PC_W-1:0];
    else m_prof[idx - REG_PHASE_WORD_FIRST] = phase_t'(val[WORD_W-1:0]);
  endtask

  function automatic logic [WORD_W-1:0] pack_phase(input int s, input int e, input int mn,
                                                    input int mx, input logic rate);
    phase_t p;
    p.start_c = TEMP_W'(s);
    p.end_c = TEMP_W'(e);
    p.min_ms = MS_W'(mn);
    p.max_ms = MS_W'(mx);
    p.rate = rate;
    return WORD_W'(p);
  endfunction

  function automatic int rand_ms(input int hi);
    if ($urandom_range(19) == 0) return (1 << MS_W) - 1;
    if ($urandom_range(9) == 0) return 0;
    return $urandom_range(hi);
  endfunction

  task automatic load_profile(input int cnt);
    int k;
    write_reg(REG_PHASE_COUNT, DATA_W'(cnt));
    for (k = 0; k < PHASE_SLOTS; k++) begin
      write_reg(REG_IDX_W'(REG_PHASE_WORD_FIRST + k),
                DATA_W'(pack_phase($urandom_range(511), $urandom_range(511), rand_ms(60),
                                   rand_ms(150), $urandom_range(3) == 0)));
    end
    @(negedge clk);
  endtask

  function automatic int pick_temp();
    int v;
    case ($urandom_range(2))
      0: v = int'($urandom_range(9215)) - 1024;
      1: begin
        v = int'(m_prof[$urandom_range(PHASE_SLOTS - 1)].end_c) * 16 + int'($urandom_range(6)) - 3;
        if (v > 8191) v = 8191;
      end
      default: v = 8191 - int'($urandom_range(200));
    endcase
    return v;
  endfunction

  task automatic queue_run(input int count);
    int k;
    int left_in_seq;
    logic [TIME_W-1:0] t;
    left_in_seq = 0;
    t = $urandom;
    for (k = 0; k < count; k++) begin
      if ($urandom_range(99) < 8) begin
        push_cmd(1'($urandom_range(1)), $urandom, int'($urandom_range(9215)) - 1024);
      end else if (left_in_seq == 0) begin
        if ($urandom_range(3) == 0) t = 32'hFFFF_FFFF - $urandom_range(400);
        else t = $urandom;
        push_cmd(ACT_START, t, pick_temp());
        left_in_seq = $urandom_range(80, 10);
      end else begin
        if ($urandom_range(9) == 0) t = t + $urandom_range(3000, 200);
        else t = t + $urandom_range(30);
        push_cmd(ACT_TICK, t, pick_temp());
        left_in_seq--;
      end
    end
  endtask

  task automatic drain();
    do @(negedge clk); while (oven_cmds.size() != 0 || in_valid || status_due.size() != 0);
  endtask

  initial begin
    #4_000_000;
    $display("FAIL");
    $finish;
  end

  initial begin
    int r;
    logic [TIME_W-1:0] ts;
    rst = 1'b1;
    in_valid = 1'b0;
    action = ACT_TICK;
    now_ms = '0;
    actual_temp_q4 = '0;
    out_ready = 1'b0;
    psel = 1'b0;
    penable = 1'b0;
    pwrite = 1'b0;
    paddr = '0;
    pwdata = '0;
    long_hold_req = 1'b0;
    send_idle = 31;
    recv_idle = 82;
    m_count = PHASE_COUNT_RESET;
    for (r = 0; r < PHASE_SLOTS; r++) m_prof[r] = phase_t'(WORD_RESET[r]);
    m_phase = '0;
    m_done = 1'b0;
    m_reflow_t = '0;
    m_phase_t = '0;
    m_stamped = 1'b0;
    repeat (12) @(posedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // reset profile: tick before start, temperature extremes, max-time exits, wrap
    push_cmd(ACT_TICK, 32'd0, 0);
    push_cmd(ACT_START, 32'd1000, 0);
    push_cmd(ACT_TICK, 32'd1000, -1024);
    push_cmd(ACT_TICK, 32'd1001, 8191);
    ts = 32'd1001 + 32'd262148;
    push_cmd(ACT_TICK, ts, 100);
    for (r = 0; r < 4; r++) begin
      ts = ts + 32'd300000;
      push_cmd(ACT_TICK, ts, 8191);
    end
    push_cmd(ACT_TICK, ts + 32'd1, 0);
    push_cmd(ACT_START, 32'hFFFF_FFF0, 5000);
    push_cmd(ACT_TICK, 32'h0000_0010, 8191);
    drain();

    // no phases in use
    write_reg(REG_PHASE_COUNT, DATA_W'(0));
    @(negedge clk);
    push_cmd(ACT_START, 32'd5, 0);
    push_cmd(ACT_TICK, 32'd6, 8191);
    push_cmd(ACT_TICK, 32'd7, 0);
    drain();

    // count above the limit, max-rate, zero-length, all-ones and all-zero phases
    write_reg(REG_PHASE_COUNT, DATA_W'(7));
    write_reg(REG_IDX_W'(REG_PHASE_WORD_FIRST + 0), DATA_W'(pack_phase(25, 150, 10, 20, 1'b1)));
    write_reg(REG_IDX_W'(REG_PHASE_WORD_FIRST + 1), DATA_W'(pack_phase(150, 180, 0, 50, 1'b0)));
    write_reg(REG_IDX_W'(REG_PHASE_WORD_FIRST + 2), {{(DATA_W - WORD_W){1'b0}}, {WORD_W{1'b1}}});
    write_reg(REG_IDX_W'(REG_PHASE_WORD_FIRST + 3), DATA_W'(0));
    write_reg(REG_IDX_W'(REG_PHASE_WORD_FIRST + 4), DATA_W'(pack_phase(511, 0, 100, 300, 1'b0)));
    write_reg(REG_IDX_W'(REG_PHASE_WORD_FIRST + 5), DATA_W'(pack_phase(0, 511, 1, 2, 1'b0)));
    @(negedge clk);
    push_cmd(ACT_START, 32'd100, 0);
    push_cmd(ACT_TICK, 32'd100, 0);
    push_cmd(ACT_TICK, 32'd130, 8191);
    push_cmd(ACT_TICK, 32'd131, 8191);
    push_cmd(ACT_TICK, 32'd132, -1);
    push_cmd(ACT_TICK, 32'd132 + 32'd262143, 8191);
    push_cmd(ACT_TICK, 32'd262300, 0);
    push_cmd(ACT_TICK, 32'd262350, 8191);
    push_cmd(ACT_TICK, 32'd262800, 0);
    push_cmd(ACT_TICK, 32'd262801, 0);
    drain();

    for (r = 0; r < 8; r++) begin
      if (r == 3) begin
        send_idle = 82;
        recv_idle = 31;
      end
      if (r == 6) begin
        send_idle = 0;
        recv_idle = 0;
      end
      load_profile(ROUND_COUNTS[r]);
      queue_run(ROUND_ITEMS / 2);
      if (r == 1) long_hold_req = 1'b1;
      drain();
      queue_run(ROUND_ITEMS / 2);
      drain();
    end

    repeat (SETTLE_CYCLES) @(posedge clk);
    if (fail_count == 0 && status_due.size() == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule
